// ===== sv/skp_pkg.sv =====
// Shared constants, codes and arithmetic helpers for the skinning palette evaluator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package skp_pkg;

  localparam int NUM_BONES = 16;
  localparam int MAX_KEYS  = 16;
  localparam int FRAC_BITS = 16;
  localparam int KEY_WORDS = 11;

  localparam int BONE_W   = $clog2(NUM_BONES);
  localparam int KEYIDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);
  localparam int KEY_AW   = $clog2(NUM_BONES * MAX_KEYS * KEY_WORDS);
  localparam int MAT_AW   = BONE_W + 4;
  localparam int FR_W     = FRAC_BITS + 1;

  // input item kinds
  localparam logic [2:0] KIND_KEY    = 3'd0;
  localparam logic [2:0] KIND_COUNT  = 3'd1;
  localparam logic [2:0] KIND_PARENT = 3'd2;
  localparam logic [2:0] KIND_OFFSET = 3'd3;
  localparam logic [2:0] KIND_EVAL   = 3'd4;

  localparam logic signed [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
    if (v > 53'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -53'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // word address of one element of one key
  function automatic logic [KEY_AW-1:0] key_addr(input logic [BONE_W-1:0] b,
                                                  input logic [KEYIDX_W-1:0] k,
                                                  input logic [3:0] e);
    return KEY_AW'((int'(b) * MAX_KEYS + int'(k)) * KEY_WORDS + int'(e));
  endfunction

  // rotation products: xx yy zz xy xz yz xw yw zw, operands index v (x=6..w=9)
  function automatic logic [3:0] rotp_a(input logic [3:0] tag);
    case (tag)
      4'd0, 4'd3, 4'd4, 4'd6: return 4'd6;
      4'd1, 4'd5, 4'd7:       return 4'd7;
      default:                return 4'd8;
    endcase
  endfunction

  function automatic logic [3:0] rotp_b(input logic [3:0] tag);
    case (tag)
      4'd0:             return 4'd6;
      4'd1, 4'd3:       return 4'd7;
      4'd2, 4'd4, 4'd5: return 4'd8;
      default:          return 4'd9;
    endcase
  endfunction

  // local entry tag i*3+e: scale row i, and the matrix slot i*4+e
  function automatic logic [3:0] loc_row(input logic [3:0] tag);
    case (tag)
      4'd0, 4'd1, 4'd2: return 4'd0;
      4'd3, 4'd4, 4'd5: return 4'd1;
      default:          return 4'd2;
    endcase
  endfunction

  function automatic logic [3:0] loc_slot(input logic [3:0] tag);
    case (tag)
      4'd0: return 4'd0;
      4'd1: return 4'd1;
      4'd2: return 4'd2;
      4'd3: return 4'd4;
      4'd4: return 4'd5;
      4'd5: return 4'd6;
      4'd6: return 4'd8;
      4'd7: return 4'd9;
      default: return 4'd10;
    endcase
  endfunction

endpackage

// ===== sv/skp_in_if.sv =====
// Input channel of the skinning palette evaluator: valid/ready plus load or evaluate payload.
// Depends on skp_pkg.
`timescale 1ns / 1ps
interface skp_in_if import skp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [2:0]                 kind;
  logic [BONE_W-1:0]          bone;
  logic [KEYIDX_W-1:0]        key;
  logic [3:0]                 element;
  logic signed [31:0]         value;

  modport source(output valid, kind, bone, key, element, value, input ready);
  modport sink(input valid, kind, bone, key, element, value, output ready);
endinterface

// ===== sv/skp_out_if.sv =====
// Result channel of the skinning palette evaluator: one matrix row per beat.
// Depends on skp_pkg.
`timescale 1ns / 1ps
interface skp_out_if import skp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BONE_W-1:0]   out_bone;
  logic [1:0]          out_row;
  logic signed [31:0]  m0;
  logic signed [31:0]  m1;
  logic signed [31:0]  m2;
  logic signed [31:0]  m3;
  logic                last;

  modport source(output valid, out_bone, out_row, m0, m1, m2, m3, last, input ready);
  modport sink(input valid, out_bone, out_row, m0, m1, m2, m3, last, output ready);
endinterface

// ===== sv/skinning_palette_evaluator.sv =====
// Top level of the skinning palette evaluator: key, offset and root memories, search,
// divider, one shared rounding multiplier pipeline and the bone sequencer.
// Depends on skp_pkg, skp_in_if and skp_out_if.
//
// Load beats (key element, key count, parent, offset element) are taken one per cycle while idle.
// An evaluate beat walks the bones in use one after another; per bone it runs a key
// search of one read per key, a 17-step divider, and then lerp, rotation, local matrix
// and one or two 4x4 matrix products streamed through the single multiplier (one
// product issued per cycle), each matrix product being 64 reads of the root memory and
// of the offset memory or the local matrix. Four result rows per bone leave through an
// output register; a stalled sink holds the sequencer at that bone. No further input is
// taken until the last row of an evaluation is in the output register. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
module skinning_palette_evaluator import skp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  skp_in_if.sink            in_if,
  skp_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [4:0]        cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BONE  = 4'd1;
  localparam logic [3:0] S_T0W   = 4'd2;
  localparam logic [3:0] S_TLW   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_LERP  = 4'd6;
  localparam logic [3:0] S_ROTP  = 4'd7;
  localparam logic [3:0] S_LOCAL = 4'd8;
  localparam logic [3:0] S_COPY  = 4'd9;
  localparam logic [3:0] S_MM1   = 4'd10;
  localparam logic [3:0] S_MM2   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  localparam logic [6:0] LEN_LERP = 7'(2 * (KEY_WORDS - 1));
  localparam logic [6:0] LEN_ROT  = 7'd9;
  localparam logic [6:0] LEN_MM   = 7'd64;

  // memories
  logic signed [31:0] key_mem [NUM_BONES*MAX_KEYS*KEY_WORDS];
  logic signed [31:0] off_mem [NUM_BONES*16];
  logic signed [31:0] root_mem [NUM_BONES*16];
  logic signed [31:0] key_rd_r, off_rd_r, root_rd_r;
  logic [KEY_AW-1:0]  key_ra;
  logic [MAT_AW-1:0]  off_ra, root_ra, root_wa;
  logic               root_we;
  logic signed [31:0] root_wd;

  // per-bone tables and configuration
  logic [CNT_W-1:0]   cnt_r [NUM_BONES];
  logic [BONE_W-1:0]  parent_r [NUM_BONES];
  logic [4:0]         bone_count_r;

  // sequencer
  logic [3:0]          state_r, state_nxt;
  logic [BONE_W-1:0]   b_r;
  logic [4:0]          nb_r;
  logic signed [31:0]  t_r;
  logic [CNT_W-1:0]    n_r;
  logic [BONE_W-1:0]   p_r;
  logic signed [31:0]  t0_r, prev_r;
  logic [KEYIDX_W-1:0] j_r, k0_r, k1_r;
  logic [FR_W-1:0]     f_r;
  logic [34:0]         rem_r;
  logic [32:0]         den_r;
  logic [4:0]          dcnt_r;
  logic [6:0]          iss_r;
  logic [1:0]          row_r;

  // values and matrices
  logic signed [31:0]  v_r [KEY_WORDS-1];
  logic signed [31:0]  prod_r [9];
  logic signed [31:0]  loc_r [16];
  logic [127:0]        fin_r [4];
  logic signed [31:0]  satrot [9];
  logic signed [52:0]  rot [9];

  // multiplier pipeline
  logic               v1_r, v2_r, v3_r;
  logic [6:0]         tag1_r, tag2_r, tag3_r;
  logic signed [31:0] hold_r, kp2_r, kp3_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] p_mul_r;
  logic [66:0]        rsum;
  logic signed [49:0] rnd_r;
  logic signed [51:0] acc_r;
  logic signed [52:0] mm_sum;
  logic               piped, issue, drained, mul_go;
  logic [6:0]         len;

  logic               in_acc, out_acc, last_bone, emit_go;
  logic [KEYIDX_W-1:0] n_last;
  logic [KEYIDX_W:0]  j_next2;
  logic signed [32:0] num_w, den_w;

  assign in_acc  = in_if.valid & in_if.ready;
  assign out_acc = out_if.valid & out_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign last_bone = (5'(b_r) == nb_r - 5'd1);
  assign n_last  = KEYIDX_W'(n_r - CNT_W'(1));
  assign j_next2 = (KEYIDX_W+1)'(j_r) + (KEYIDX_W+1)'(2);
  assign emit_go = (state_r == S_EMIT) && (!out_if.valid || out_if.ready);

  // scan bracket candidates: prev_r is the lower key time, key_rd_r the upper
  assign num_w = 33'(t_r) - 33'(prev_r);
  assign den_w = 33'(key_rd_r) - 33'(prev_r);

  // phase lengths of the streamed phases
  always_comb begin
    piped = 1'b1;
    len   = LEN_MM;
    case (state_r)
      S_LERP:         len = LEN_LERP;
      S_ROTP, S_LOCAL: len = LEN_ROT;
      S_MM1, S_MM2:   len = LEN_MM;
      default:        piped = 1'b0;
    endcase
  end
  assign issue   = piped && (iss_r < len);
  assign drained = piped && (iss_r == len) && !v1_r && !v2_r && !v3_r;

  // rotation entries from the rounded products
  always_comb begin
    rot[0] = 53'(ONE_FX) - 53'sd2 * (53'(prod_r[1]) + 53'(prod_r[2]));
    rot[1] = 53'sd2 * (53'(prod_r[3]) + 53'(prod_r[8]));
    rot[2] = 53'sd2 * (53'(prod_r[4]) - 53'(prod_r[7]));
    rot[3] = 53'sd2 * (53'(prod_r[3]) - 53'(prod_r[8]));
    rot[4] = 53'(ONE_FX) - 53'sd2 * (53'(prod_r[0]) + 53'(prod_r[2]));
    rot[5] = 53'sd2 * (53'(prod_r[5]) + 53'(prod_r[6]));
    rot[6] = 53'sd2 * (53'(prod_r[4]) + 53'(prod_r[7]));
    rot[7] = 53'sd2 * (53'(prod_r[5]) - 53'(prod_r[6]));
    rot[8] = 53'(ONE_FX) - 53'sd2 * (53'(prod_r[0]) + 53'(prod_r[1]));
    for (int i = 0; i < 9; i++) satrot[i] = sat32(rot[i]);
  end

  // memory read addresses
  always_comb begin
    key_ra  = key_addr(b_r, '0, 4'd0);
    off_ra  = {b_r, iss_r[3:0]};
    root_ra = {b_r, iss_r[1:0], iss_r[5:4]};
    case (state_r)
      S_T0W:  key_ra = key_addr(b_r, n_last, 4'd0);
      S_TLW:  key_ra = key_addr(b_r, KEYIDX_W'(1), 4'd0);
      S_SCAN: key_ra = key_addr(b_r, j_next2[KEYIDX_W-1:0], 4'd0);
      S_LERP: key_ra = key_addr(b_r, iss_r[0] ? k1_r : k0_r, iss_r[4:1] + 4'd1);
      S_MM1:  root_ra = {p_r, iss_r[1:0], iss_r[3:2]};
      default: ;
    endcase
  end

  // multiplier operands at the read-data stage
  always_comb begin
    ma = 33'(off_rd_r);
    mb = 33'(root_rd_r);
    case (state_r)
      S_LERP: begin
        ma = 33'(key_rd_r) - 33'(hold_r);
        mb = $signed(33'(f_r));
      end
      S_ROTP: begin
        ma = 33'(v_r[rotp_a(tag1_r[3:0])]);
        mb = 33'(v_r[rotp_b(tag1_r[3:0])]);
      end
      S_LOCAL: begin
        ma = 33'(v_r[loc_row(tag1_r[3:0])]);
        mb = 33'(satrot[tag1_r[3:0]]);
      end
      S_MM1: ma = 33'(loc_r[{tag1_r[5:4], tag1_r[1:0]}]);
      default: ;
    endcase
  end
  assign mul_go = v1_r && !((state_r == S_LERP) && !tag1_r[0]);

  // round to nearest, ties away from zero
  assign rsum = 67'(p_mul_r) + 67'(64'd1 << (FRAC_BITS - 1)) - 67'(p_mul_r[65]);
  assign mm_sum = (tag3_r[1:0] == 2'd0) ? 53'(rnd_r) : 53'(acc_r) + 53'(rnd_r);

  // root memory write: copy of the local matrix, or a finished product entry
  always_comb begin
    root_we = 1'b0;
    root_wa = {b_r, iss_r[3:0]};
    root_wd = loc_r[iss_r[3:0]];
    if (state_r == S_COPY) begin
      root_we = 1'b1;
    end else if (state_r == S_MM1 && v3_r && tag3_r[1:0] == 2'd3) begin
      root_we = 1'b1;
      root_wa = {b_r, tag3_r[5:2]};
      root_wd = sat32(mm_sum);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && in_if.kind == KIND_EVAL) state_nxt = S_BONE;
      S_BONE: begin
        if (cnt_r[b_r] == '0) begin
          state_nxt = (parent_r[b_r] >= b_r) ? S_COPY : S_MM1;
        end else begin
          state_nxt = S_T0W;
        end
      end
      S_T0W: state_nxt = S_TLW;
      S_TLW: begin
        if (t_r <= t0_r || t_r >= key_rd_r) state_nxt = S_LERP;
        else state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (t_r >= prev_r && t_r <= key_rd_r) begin
          state_nxt = (den_w == '0) ? S_LERP : S_DIV;
        end else if (!(5'(j_next2) < 5'(n_r))) begin
          state_nxt = S_LERP;
        end
      end
      S_DIV:   if (dcnt_r == 5'(FR_W - 1)) state_nxt = S_LERP;
      S_LERP:  if (drained) state_nxt = S_ROTP;
      S_ROTP:  if (drained) state_nxt = S_LOCAL;
      S_LOCAL: if (drained) state_nxt = (p_r >= b_r) ? S_COPY : S_MM1;
      S_COPY:  if (iss_r[3:0] == 4'd15) state_nxt = S_MM2;
      S_MM1:   if (drained) state_nxt = S_MM2;
      S_MM2:   if (drained) state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_go && row_r == 2'd3) state_nxt = last_bone ? S_IDLE : S_BONE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      bone_count_r <= 5'd16;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_if.valid <= 1'b0;
      for (int i = 0; i < NUM_BONES; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= issue;
      v2_r    <= mul_go;
      v3_r    <= v2_r;
      if (cfg_we) bone_count_r <= cfg_wdata;
      if (in_acc && in_if.kind == KIND_COUNT && 32'(in_if.bone) < NUM_BONES) begin
        if (in_if.value < 0) cnt_r[in_if.bone] <= '0;
        else if (in_if.value > MAX_KEYS) cnt_r[in_if.bone] <= CNT_W'(MAX_KEYS);
        else cnt_r[in_if.bone] <= in_if.value[CNT_W-1:0];
      end
      if (emit_go) out_if.valid <= 1'b1;
      else if (out_acc) out_if.valid <= 1'b0;
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    key_rd_r  <= key_mem[key_ra];
    off_rd_r  <= off_mem[off_ra];
    root_rd_r <= root_mem[root_ra];
    if (in_acc && in_if.kind == KIND_KEY && 32'(in_if.bone) < NUM_BONES &&
        32'(in_if.key) < MAX_KEYS && 32'(in_if.element) < KEY_WORDS) begin
      key_mem[key_addr(in_if.bone, in_if.key, in_if.element)] <= in_if.value;
    end
    if (in_acc && in_if.kind == KIND_OFFSET && 32'(in_if.bone) < NUM_BONES) begin
      off_mem[{in_if.bone, in_if.element}] <= in_if.value;
    end
    if (root_we) root_mem[root_wa] <= root_wd;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // loads and evaluate start
    if (in_acc && in_if.kind == KIND_PARENT && 32'(in_if.bone) < NUM_BONES) begin
      parent_r[in_if.bone] <= in_if.value[BONE_W-1:0];
    end
    if (in_acc && in_if.kind == KIND_EVAL) begin
      t_r <= in_if.value;
      b_r <= '0;
      if (bone_count_r == 5'd0) nb_r <= 5'd1;
      else if (32'(bone_count_r) > NUM_BONES) nb_r <= 5'(NUM_BONES);
      else nb_r <= bone_count_r;
    end

    // phase counter
    if (state_nxt != state_r) iss_r <= '0;
    else if (issue || state_r == S_COPY) iss_r <= iss_r + 7'd1;

    case (state_r)
      S_BONE: begin
        n_r <= cnt_r[b_r];
        p_r <= parent_r[b_r];
        row_r <= 2'd0;
        if (cnt_r[b_r] == '0) begin
          for (int i = 0; i < 16; i++) loc_r[i] <= (i % 5 == 0) ? ONE_FX : 32'sd0;
        end
      end
      S_T0W: begin
        t0_r <= key_rd_r;
        prev_r <= key_rd_r;
      end
      S_TLW: begin
        f_r <= '0;
        j_r <= '0;
        if (t_r <= t0_r) begin
          k0_r <= '0;
          k1_r <= '0;
        end else begin
          k0_r <= n_last;
          k1_r <= n_last;
        end
      end
      S_SCAN: begin
        if (t_r >= prev_r && t_r <= key_rd_r) begin
          k0_r   <= j_r;
          k1_r   <= j_r + KEYIDX_W'(1);
          rem_r  <= 35'(num_w[31:0]);
          den_r  <= den_w;
          dcnt_r <= '0;
        end else begin
          prev_r <= key_rd_r;
          j_r    <= j_r + KEYIDX_W'(1);
          k0_r   <= n_last;
          k1_r   <= n_last;
        end
      end
      // restoring division, one quotient bit a cycle
      S_DIV: begin
        dcnt_r <= dcnt_r + 5'd1;
        if (rem_r >= 35'(den_r)) begin
          rem_r <= 35'((rem_r - 35'(den_r)) << 1);
          f_r   <= {f_r[FR_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_r << 1;
          f_r   <= {f_r[FR_W-2:0], 1'b0};
        end
      end
      S_ROTP: begin
        if (drained) begin
          loc_r[3]  <= 32'sd0;
          loc_r[7]  <= 32'sd0;
          loc_r[11] <= 32'sd0;
          loc_r[12] <= v_r[3];
          loc_r[13] <= v_r[4];
          loc_r[14] <= v_r[5];
          loc_r[15] <= ONE_FX;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_if.out_bone <= b_r;
          out_if.out_row  <= row_r;
          out_if.m0 <= fin_r[row_r][31:0];
          out_if.m1 <= fin_r[row_r][63:32];
          out_if.m2 <= fin_r[row_r][95:64];
          out_if.m3 <= fin_r[row_r][127:96];
          out_if.last <= last_bone && row_r == 2'd3;
          row_r <= row_r + 2'd1;
          if (row_r == 2'd3) b_r <= b_r + BONE_W'(1);
        end
      end
      default: ;
    endcase

    // multiplier pipeline: read data, product, rounded product
    tag1_r <= iss_r;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    if (v1_r && !mul_go) hold_r <= key_rd_r;
    kp2_r   <= hold_r;
    kp3_r   <= kp2_r;
    p_mul_r <= ma * mb;
    rnd_r   <= $signed(rsum[FRAC_BITS+49:FRAC_BITS]);

    // consume rounded products
    if (v3_r) begin
      case (state_r)
        S_LERP:  v_r[tag3_r[4:1]] <= sat32(53'(kp3_r) + 53'(rnd_r));
        S_ROTP:  prod_r[tag3_r[3:0]] <= sat32(53'(rnd_r));
        S_LOCAL: loc_r[loc_slot(tag3_r[3:0])] <= sat32(53'(rnd_r));
        S_MM1:   acc_r <= mm_sum[51:0];
        S_MM2: begin
          acc_r <= mm_sum[51:0];
          if (tag3_r[1:0] == 2'd3) fin_r[tag3_r[5:4]][tag3_r[3:2]*32 +: 32] <= sat32(mm_sum);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/skp_checker.sv =====
// Port-level checks of the skinning palette evaluator, bound to the top level.
// Depends on skp_pkg and skinning_palette_evaluator.
`timescale 1ns / 1ps
module skp_checker import skp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [2:0]        in_kind,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_row,
  input logic [BONE_W-1:0] out_bone,
  input logic              out_last,
  input logic signed [31:0] out_m0
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row) && $stable(out_bone)
      && $stable(out_m0))
    else $error("result beat changed under stall");

  // an evaluate beat closes the input once it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_kind == KIND_EVAL |=> !in_ready)
    else $error("input open right after evaluate");

  // last marks only the final row of a bone
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row == 2'd3)
    else $error("last on a row other than 3");

  // while a non-final row waits, the evaluation is still running
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input open during evaluation");

endmodule

bind skinning_palette_evaluator skp_checker u_skp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_if.valid),
  .in_ready(in_if.ready),
  .in_kind(in_if.kind),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_row(out_if.out_row),
  .out_bone(out_if.out_bone),
  .out_last(out_if.last),
  .out_m0(out_if.m0)
);

// ===== test/testbench.sv =====
// Self-checking testbench for skinning_palette_evaluator: loads keys, parents and offsets,
// evaluates palettes and checks every row against an in-bench fixed-point predictor.
// Depends on skp_pkg, skp_in_if, skp_out_if and the skinning_palette_evaluator RTL.
`timescale 1ns / 1ps
module testbench;
  import skp_pkg::*;

  // key element layout
  localparam int KEY_TIME  = 0;
  localparam int KEY_SCALE = 1;
  localparam int KEY_TRANS = 4;
  localparam int KEY_QUAT  = 7;
  localparam logic [10:0] KEY_FULL = 11'h7ff;
  // kinds the block ignores
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic [3:0] bone;
    logic [1:0] row;
    int         m0, m1, m2, m3;
    bit         last;
  } palette_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  skp_in_if  in_ch ();
  skp_out_if out_ch ();

  skinning_palette_evaluator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // shadow state of the block
  int          key_mem [16][16][11];
  int          cnt_mem [16];
  int          par_mem [16];
  int          off_mem [16][16];
  int          root_mem[16][16];
  logic [4:0]  bone_cfg;
  logic [10:0] key_mask[16][16];

  palette_row_t palette_q[$];
  int  errors;
  bit  no_idle;

  // clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // fixed-point arithmetic
  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q(longint a, longint b);
    longint p;
    longint unsigned mag;
    bit neg;
    p = a * b;
    neg = p < 0;
    mag = neg ? longint'(-p) : p;
    mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic void mat_mul(input int a[16], input int bm[16], output int c[16]);
    longint s;
    for (int r = 0; r < 4; r++) begin
      for (int col = 0; col < 4; col++) begin
        s = 0;
        for (int k = 0; k < 4; k++) s += mul_q(a[r*4+k], bm[k*4+col]);
        c[r*4+col] = int'(sat_q(s));
      end
    end
  endfunction

  // interpolated local transform of one bone at time t
  function automatic void build_local(input int b, input longint t, output int m[16]);
    int n, k0, k1;
    longint f, a, c, x, y, z, w, xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint v[11];
    longint rot[9];
    longint unsigned num, den;
    bit found;
    n = cnt_mem[b];
    for (int i = 0; i < 16; i++) m[i] = 0;
    if (n == 0) begin
      for (int i = 0; i < 4; i++) m[i*5] = ONE_FX;
      return;
    end
    k0 = 0;
    k1 = 0;
    f = 0;
    if (t <= key_mem[b][0][KEY_TIME]) begin
      k0 = 0;
    end else if (t >= key_mem[b][n-1][KEY_TIME]) begin
      k0 = n - 1;
      k1 = n - 1;
    end else begin
      found = 0;
      for (int j = 0; j + 1 < n && !found; j++) begin
        a = key_mem[b][j][KEY_TIME];
        c = key_mem[b][j+1][KEY_TIME];
        if (t >= a && t <= c) begin
          num = t - a;
          den = c - a;
          k0 = j;
          k1 = j + 1;
          f = (den != 0) ? longint'((num << FRAC_BITS) / den) : 0;
          found = 1;
        end
      end
      if (!found) begin
        k0 = n - 1;
        k1 = n - 1;
      end
    end
    for (int e = 1; e < 11; e++)
      v[e] = sat_q(longint'(key_mem[b][k0][e]) +
                   mul_q(longint'(key_mem[b][k1][e]) - longint'(key_mem[b][k0][e]), f));
    x = v[KEY_QUAT]; y = v[KEY_QUAT+1]; z = v[KEY_QUAT+2]; w = v[KEY_QUAT+3];
    xx = sat_q(mul_q(x, x)); yy = sat_q(mul_q(y, y)); zz = sat_q(mul_q(z, z));
    xy = sat_q(mul_q(x, y)); xz = sat_q(mul_q(x, z)); yz = sat_q(mul_q(y, z));
    xw = sat_q(mul_q(x, w)); yw = sat_q(mul_q(y, w)); zw = sat_q(mul_q(z, w));
    rot[0] = ONE_FX - 2*(yy+zz); rot[1] = 2*(xy+zw); rot[2] = 2*(xz-yw);
    rot[3] = 2*(xy-zw); rot[4] = ONE_FX - 2*(xx+zz); rot[5] = 2*(yz+xw);
    rot[6] = 2*(xz+yw); rot[7] = 2*(yz-xw); rot[8] = ONE_FX - 2*(xx+yy);
    for (int i = 0; i < 3; i++) begin
      for (int e = 0; e < 3; e++)
        m[i*4+e] = int'(sat_q(mul_q(v[KEY_SCALE+i], sat_q(rot[i*3+e]))));
      m[12+i] = int'(v[KEY_TRANS+i]);
    end
    m[15] = ONE_FX;
  endfunction

  // update shadow state for one accepted beat, queue the palette rows it causes
  function automatic void predict_palette(logic [2:0] kind, int b, int k, int e, int val);
    int n;
    int loc[16], fin[16], rt[16], pr[16], off[16];
    palette_row_t row;
    case (kind)
      KIND_KEY: if (e < KEY_WORDS) key_mem[b][k][e] = val;
      KIND_COUNT: cnt_mem[b] = (val < 0) ? 0 : ((val > MAX_KEYS) ? MAX_KEYS : val);
      KIND_PARENT: par_mem[b] = val & 15;
      KIND_OFFSET: off_mem[b][e] = val;
      KIND_EVAL: begin
        n = (bone_cfg < 1) ? 1 : ((bone_cfg > NUM_BONES) ? NUM_BONES : bone_cfg);
        for (int bi = 0; bi < n; bi++) begin
          build_local(bi, longint'(val), loc);
          if (bi == 0 || par_mem[bi] >= bi) begin
            rt = loc;
          end else begin
            pr = root_mem[par_mem[bi]];
            mat_mul(loc, pr, rt);
          end
          root_mem[bi] = rt;
          off = off_mem[bi];
          mat_mul(off, rt, fin);
          for (int r = 0; r < 4; r++) begin
            row.bone = bi;
            row.row  = r;
            row.m0 = fin[r]; row.m1 = fin[4+r]; row.m2 = fin[8+r]; row.m3 = fin[12+r];
            row.last = (bi == n - 1 && r == 3);
            palette_q.push_back(row);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // send one input beat, then predict from it
  task automatic send_beat(logic [2:0] kind, int b, int k, int e, int val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.bone    <= b;
    in_ch.key     <= k;
    in_ch.element <= e;
    in_ch.value   <= val;
    do @(posedge clk); while (!in_ch.ready);
    predict_palette(kind, b, k, e, val);
    if (kind == KIND_KEY && e < KEY_WORDS) key_mask[b][k][e] = 1'b1;
  endtask

  // drain, then write bone_count while the block is idle
  task automatic set_bone_count(logic [4:0] v);
    in_ch.valid <= 1'b0;
    wait (palette_q.size() == 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    bone_cfg = v;
  endtask

  // random key element content, mostly plausible
  function automatic int key_value(int k, int e);
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (e == KEY_TIME) return k * 32'h8000 + $urandom_range(0, 16383);
    if (e < KEY_TRANS) return ONE_FX + $urandom_range(0, 65535) - 32768;
    if (e < KEY_QUAT) return $urandom_range(0, 32'h10_0000) - 32'h8_0000;
    return $urandom_range(0, 32'h2_0000) - 32'h1_0000;
  endfunction

  function automatic int eval_time();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return key_mem[$urandom_range(0, 15)][$urandom_range(0, 15)][KEY_TIME];
      default: return $urandom_range(0, 32'h9_0000) - 32'h1_0000;
    endcase
  endfunction

  // number of leading keys of a bone that are fully written
  function automatic int keys_ready(int b);
    int n;
    n = 0;
    while (n < MAX_KEYS && key_mask[b][n] == KEY_FULL) n++;
    return n;
  endfunction

  task automatic load_key(int b, int k);
    for (int e = 0; e < KEY_WORDS; e++) send_beat(KIND_KEY, b, k, e, key_value(k, e));
  endtask

  // parents and offsets for every bone, counts zero
  task automatic test_reset_identity();
    for (int b = 0; b < NUM_BONES; b++) begin
      send_beat(KIND_PARENT, b, 0, 0, $urandom_range(0, 15));
      for (int e = 0; e < 16; e++)
        send_beat(KIND_OFFSET, b, 0, e,
                  (e % 5 == 0) ? ONE_FX : $urandom_range(0, 32'h4_0000) - 32'h2_0000);
    end
    send_beat(KIND_EVAL, 0, 0, 0, 32'sh8000_0000);
    send_beat(KIND_EVAL, 0, 0, 0, 32'sh7fff_ffff);
  endtask

  // one key, equal times, descending times, full and saturated counts
  task automatic test_key_cases();
    int t;
    load_key(1, 0);
    send_beat(KIND_COUNT, 1, 0, 0, 1);
    load_key(2, 0);
    load_key(2, 1);
    send_beat(KIND_KEY, 2, 1, KEY_TIME, key_mem[2][0][KEY_TIME]);
    send_beat(KIND_COUNT, 2, 0, 0, 2);
    for (int k = 0; k < 3; k++) begin
      load_key(3, k);
      send_beat(KIND_KEY, 3, k, KEY_TIME, 32'h3_0000 - k * 32'h1_0000);
    end
    send_beat(KIND_COUNT, 3, 0, 0, 3);
    for (int k = 0; k < MAX_KEYS; k++) load_key(4, k);
    send_beat(KIND_COUNT, 4, 0, 0, 100);
    send_beat(KIND_COUNT, 5, 0, 0, -7);
    load_key(6, 0);
    load_key(6, 1);
    send_beat(KIND_KEY, 6, 1, KEY_TIME, 32'sh7fff_ffff);
    for (int e = 1; e < KEY_WORDS; e++) begin
      send_beat(KIND_KEY, 6, 0, e, (e & 1) ? 32'sh7fff_ffff : 32'sh8000_0000);
      send_beat(KIND_KEY, 6, 1, e, (e & 1) ? 32'sh8000_0000 : 32'sh7fff_ffff);
    end
    send_beat(KIND_COUNT, 6, 0, 0, 2);
    send_beat(KIND_PARENT, 7, 0, 0, 32'hffff_fff3);
    send_beat(KIND_PARENT, 3, 0, 0, 3);
    send_beat(KIND_PARENT, 0, 0, 0, 5);
    send_beat(KIND_EVAL, 0, 0, 0, -32'sd65536);
    t = key_mem[4][5][KEY_TIME];
    send_beat(KIND_EVAL, 0, 0, 0, t);
    send_beat(KIND_EVAL, 0, 0, 0, t + 1234);
    send_beat(KIND_EVAL, 0, 0, 0, 32'h0002_4000);
    send_beat(KIND_EVAL, 0, 0, 0, 32'h4000_0000);
  endtask

  // beats the block must drop, then one evaluation
  task automatic test_ignored_items();
    for (logic [2:0] kd = KIND_SPARE_LO; kd <= KIND_SPARE_HI && kd != 0; kd++)
      send_beat(kd, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom);
    for (int e = KEY_WORDS; e < 16; e++)
      send_beat(KIND_KEY, $urandom_range(0, 15), $urandom_range(0, 15), e, $urandom);
    send_beat(KIND_EVAL, 0, 0, 0, eval_time());
  endtask

  // bone_count extremes and clamping
  task automatic test_bone_count();
    logic [4:0] vals[5] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd3};
    foreach (vals[i]) begin
      set_bone_count(vals[i]);
      send_beat(KIND_EVAL, 0, 0, 0, eval_time());
      send_beat(KIND_EVAL, 0, 0, 0, eval_time());
    end
  endtask

  // random mix of loads, noise and evaluations over several settings
  task automatic test_random();
    int r, b, k, n, v;
    for (int phase = 0; phase < 4; phase++) begin
      set_bone_count(phase == 0 ? 5'd16 : (phase == 3 ? 5'd8 : $urandom_range(1, 16)));
      no_idle = (phase == 2);
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(0, 99);
        b = $urandom_range(0, 15);
        if (r < 32) begin
          k = $urandom_range(0, 15);
          v = $urandom_range(0, KEY_WORDS - 1);
          send_beat(KIND_KEY, b, k, v, key_value(k, v));
        end else if (r < 40) begin
          n = keys_ready(b);
          if (n < MAX_KEYS) load_key(b, n);
        end else if (r < 52) begin
          n = $urandom_range(0, keys_ready(b));
          if (n == MAX_KEYS && $urandom_range(0, 1)) v = $urandom_range(17, 32'h7fff_ffff);
          else if (n == 0 && $urandom_range(0, 1)) v = 32'sh8000_0000 | $urandom;
          else v = n;
          send_beat(KIND_COUNT, b, 0, 0, v);
        end else if (r < 58) begin
          send_beat(KIND_PARENT, b, 0, 0, $urandom);
        end else if (r < 68) begin
          v = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 32'h4_0000) - 32'h2_0000;
          send_beat(KIND_OFFSET, b, 0, $urandom_range(0, 15), v);
        end else if (r < 73) begin
          send_beat($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI), b, $urandom_range(0, 15),
                    $urandom_range(0, 15), $urandom);
        end else begin
          send_beat(KIND_EVAL, $urandom_range(0, 15), $urandom_range(0, 15),
                    $urandom_range(0, 15), eval_time());
        end
      end
    end
    no_idle = 0;
  endtask

  // result side: random stall, then check one beat against the oldest expected row
  initial begin
    palette_row_t exp_row;
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (palette_q.size() == 0) begin
        $error("unexpected row: bone %0d row %0d", out_ch.out_bone, out_ch.out_row);
        errors++;
      end else begin
        exp_row = palette_q.pop_front();
        if (out_ch.out_bone !== exp_row.bone) begin
          $error("out_bone expected %0d got %0d", exp_row.bone, out_ch.out_bone); errors++;
        end
        if (out_ch.out_row !== exp_row.row) begin
          $error("out_row expected %0d got %0d", exp_row.row, out_ch.out_row); errors++;
        end
        if (out_ch.m0 !== exp_row.m0) begin
          $error("m0 expected %0d got %0d", exp_row.m0, out_ch.m0); errors++;
        end
        if (out_ch.m1 !== exp_row.m1) begin
          $error("m1 expected %0d got %0d", exp_row.m1, out_ch.m1); errors++;
        end
        if (out_ch.m2 !== exp_row.m2) begin
          $error("m2 expected %0d got %0d", exp_row.m2, out_ch.m2); errors++;
        end
        if (out_ch.m3 !== exp_row.m3) begin
          $error("m3 expected %0d got %0d", exp_row.m3, out_ch.m3); errors++;
        end
        if (out_ch.last !== exp_row.last) begin
          $error("last expected %0d got %0d", exp_row.last, out_ch.last); errors++;
        end
      end
    end
  end

  // sequence of tests
  initial begin
    errors = 0;
    no_idle = 0;
    bone_cfg = 5'd16;
    for (int b = 0; b < 16; b++) begin
      cnt_mem[b] = 0;
      par_mem[b] = 0;
      for (int i = 0; i < 16; i++) begin
        off_mem[b][i] = 0;
        root_mem[b][i] = 0;
        key_mask[b][i] = '0;
        for (int e = 0; e < 11; e++) key_mem[b][i][e] = 0;
      end
    end
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= '0;
    in_ch.bone    <= '0;
    in_ch.key     <= '0;
    in_ch.element <= '0;
    in_ch.value   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_identity();
    test_key_cases();
    test_ignored_items();
    test_bone_count();
    test_random();
    set_bone_count(5'd16);
    send_beat(KIND_EVAL, 0, 0, 0, eval_time());
    in_ch.valid <= 1'b0;
    wait (palette_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
